>>> rtl/pvqs_pkg.sv
// ----------------------------------------------------------------------------
// pvqs_pkg
// Types and constants of the paced version query scheduler: item structs,
// action codes, sequencer states and reset values.
// ----------------------------------------------------------------------------
package pvqs_pkg;

    // default number of axes on the bus
    localparam int AXIS_COUNT_DEF = 7;

    // reset value of the re-query interval in microseconds
    localparam logic [31:0] REQUERY_RESET_US = 32'd1000000;

    // action codes of an input item
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_RECORD = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // one input item
    typedef struct packed {
        t_action     action;
        logic [2:0]  axis;
        logic [63:0] payload;
        logic [6:0]  present_mask;
        logic        commands_allowed;
        logic        tx_ready;
        logic [63:0] now_us;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic        query_sent;
        logic [2:0]  query_axis;
        logic [6:0]  reply_mask;
        logic [6:0]  queried_mask;
        logic [63:0] version_word;
        logic        version_valid;
    } t_out_item;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_DONE
    } t_state;

endpackage

>>> rtl/paced_version_query_scheduler.sv
// ----------------------------------------------------------------------------
// paced_version_query_scheduler
// Picks at most one version query per tick across the axes, with retries paced by a
// re-query interval, and keeps each axis's 64-bit reply in a small synchronous memory.
// ----------------------------------------------------------------------------
// A result is strobed on o_done from the r_done register, loaded in the update state
// that follows the access state after the start transfer. A new item is taken only
//   back in idle, after the reply memory read and the update; busy is high in both.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, i_rst_n low): masks and last send time cleared, interval
//   back to 1000000 us; memory words are masked by the received bits.
module paced_version_query_scheduler #(
    parameter int AXIS_COUNT = pvqs_pkg::AXIS_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item channel
    input  logic                 start,
    output logic                 busy,
    input  pvqs_pkg::t_in_item   i_item,
    // result channel
    output logic                 o_done,
    output pvqs_pkg::t_out_item  o_result,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_data
);
    import pvqs_pkg::*;

    localparam int AIW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    // sequencer
    t_state r_state, n_state;
    logic   rd_en;
    logic   upd_en;

    // captured item
    t_in_item r_item;

    // architectural state
    logic [AXIS_COUNT-1:0] r_got, n_got;
    logic [AXIS_COUNT-1:0] r_asked, n_asked;
    logic [63:0]           r_last_send, n_last_send;
    logic [31:0]           r_interval;

    // reply memory and its registered read port
    logic [63:0] r_cache [AXIS_COUNT];
    logic [63:0] r_rd_word;
    logic        cache_wr;

    // elapsed time since the last accepted send
    logic [63:0] r_elapsed;

    // result register
    t_out_item r_out, n_out;
    logic      r_done;

    // decoded item
    logic                  axis_ok;
    logic [AIW-1:0]        axis_idx;
    logic [AXIS_COUNT-1:0] present;
    logic [AXIS_COUNT-1:0] fresh_cand;
    logic [AXIS_COUNT-1:0] retry_cand;

    // lowest set bit of a mask, with a found flag
    function automatic logic [3:0] lowest_bit(input logic [AXIS_COUNT-1:0] m);
        logic [3:0] res;
        res = 4'd0;
        for (int i = AXIS_COUNT - 1; i >= 0; i--) begin
            if (m[i]) begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

    // axis decode and candidate masks
    always_comb begin
        axis_ok  = ({1'b0, r_item.axis} < 4'(AXIS_COUNT));
        axis_idx = r_item.axis[AIW-1:0];
        present  = '0;
        for (int i = 0; i < AXIS_COUNT; i++) begin
            if (i < 7) begin
                present[i] = r_item.present_mask[i];
            end
        end
        fresh_cand = present & ~r_asked;
        retry_cand = present & ~r_got;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) begin
                n_state = ST_ACCESS;
            end
            ST_ACCESS: n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy   = 1'b1;
        rd_en  = 1'b0;
        upd_en = 1'b0;
        unique case (r_state)
            ST_IDLE:   busy = 1'b0;
            ST_ACCESS: rd_en = axis_ok;
            ST_DONE:   upd_en = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

    // read-modify-write of the item's effect
    always_comb begin
        logic [3:0] fresh;
        logic [3:0] retry;
        fresh       = lowest_bit(fresh_cand);
        retry       = lowest_bit(retry_cand);
        n_got       = r_got;
        n_asked     = r_asked;
        n_last_send = r_last_send;
        cache_wr    = 1'b0;
        n_out       = '0;
        unique case (r_item.action)
            ACT_TICK: begin
                if (r_item.commands_allowed) begin
                    priority if (fresh[3]) begin
                        if (r_item.tx_ready) begin
                            n_asked[fresh[AIW-1:0]] = 1'b1;
                            n_last_send         = r_item.now_us;
                            n_out.query_sent    = 1'b1;
                            n_out.query_axis    = fresh[2:0];
                        end
                    end else if (r_elapsed >= {32'd0, r_interval}) begin
                        if (retry[3] && r_item.tx_ready) begin
                            n_last_send      = r_item.now_us;
                            n_out.query_sent = 1'b1;
                            n_out.query_axis = retry[2:0];
                        end
                    end
                end
            end
            ACT_RECORD: begin
                if (axis_ok) begin
                    cache_wr          = upd_en;
                    n_got[axis_idx]   = 1'b1;
                end
            end
            ACT_READ: begin
                if (axis_ok && r_got[axis_idx]) begin
                    n_out.version_word  = r_rd_word;
                    n_out.version_valid = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_got       = '0;
                n_asked     = '0;
                n_last_send = '0;
            end
            default: n_out = '0;
        endcase
        for (int i = 0; i < AXIS_COUNT; i++) begin
            if (i < 7) begin
                n_out.reply_mask[i]   = n_got[i];
                n_out.queried_mask[i] = n_asked[i];
            end
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_got       <= '0;
            r_asked     <= '0;
            r_last_send <= '0;
            r_interval  <= REQUERY_RESET_US;
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= upd_en;
            if (upd_en) begin
                r_got       <= n_got;
                r_asked     <= n_asked;
                r_last_send <= n_last_send;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_interval <= i_cfg_data;
            end
        end
    end

    // item capture, elapsed time and result payload
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_item;
        end
        if (r_state == ST_ACCESS) begin
            r_elapsed <= r_item.now_us - r_last_send;
        end
        if (upd_en) begin
            r_out <= n_out;
        end
    end

    // reply memory: read in the access cycle, written in the update cycle,
    // so one item never overlaps another on the same entry
    always_ff @(posedge i_clk) begin
        if (cache_wr) begin
            r_cache[axis_idx] <= r_item.payload;
        end
        if (rd_en) begin
            r_rd_word <= r_cache[axis_idx];
        end
    end

    assign o_done      = r_done;
    assign o_result    = r_out;
    // interval writes only between items
    assign o_cfg_ready = !busy;

    // a result only follows the update cycle
    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_DONE))
        else $error("result strobe without update cycle");

    // every item transfer yields its result strobe after the access and update states
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("item transfer without result");

    // a sent query addresses an axis that is marked as queried
    a_sent_is_queried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.query_sent) |-> o_result.queried_mask[o_result.query_axis])
        else $error("sent query axis not in queried mask");

    // no query, no axis
    a_idle_axis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.query_sent) |-> (o_result.query_axis == 3'd0))
        else $error("query axis set without a send");

endmodule
